[hw/rtl/fba_pkg.sv]
// ----------------------------------------------------------------------------
// fba_pkg: shared definitions for the free list block allocator
// Sizes of the block space and the link memory, request codes and states.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int NUM_BLOCKS = 511;
  localparam int MAX_ALLOC  = 16;

  localparam int BLK_W   = $clog2(NUM_BLOCKS + 1);
  localparam int MEM_D   = 1 << BLK_W;
  localparam int FREE_W  = $clog2(NUM_BLOCKS + 1) + 1;
  localparam int CNT_W   = $clog2(MAX_ALLOC + 1);
  localparam int REQ_W   = 5;

  typedef logic [BLK_W-1:0] blk_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  typedef struct packed {
    logic we;
    blk_t waddr;
    blk_t wdata;
    blk_t raddr;
  } mem_req_t;

endpackage

[hw/rtl/fba_link_mem.sv]
// ----------------------------------------------------------------------------
// fba_link_mem: next-link memory of the free list
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fba_link_mem import fba_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output blk_t     rdata
);

  blk_t mem [MEM_D];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read before write: a same-cycle read of the written entry returns old data.
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

[hw/rtl/free_list_block_allocator.sv]
// ----------------------------------------------------------------------------
// free_list_block_allocator: disk block allocator over a linked free list
// Allocates runs of blocks from the head of the list and frees single blocks.
// ----------------------------------------------------------------------------
// An accepted allocation of N blocks enters the pop state, which pops one
// block per cycle with one link memory read per pop and registers each result;
// busy stays high while the N pops run. Free requests, refused requests and
// zero-length allocations are handled in the idle state with busy low. After
// reset a clearing pass over all 512 entries builds the initial list with busy
// high. Results are one-cycle strobes that the receiver cannot stall.
module free_list_block_allocator import fba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [REQ_W-1:0] in_block_count,
  input  logic [BLK_W-1:0] in_block_index,
  output logic             out_valid,
  output logic [BLK_W-1:0] out_block_number,
  output logic             out_last_flag,
  output logic             out_status
);

  logic [1:0]      state_r, state_nxt;
  blk_t            head_r, head_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  blk_t            init_cnt_r, init_cnt_nxt;
  logic            fwd_r, fwd_nxt;

  logic            vld_r, vld_nxt;
  blk_t            blk_r, blk_nxt;
  logic            last_r, last_nxt;
  logic            stat_r, stat_nxt;

  mem_req_t        mreq;
  blk_t            rdata;
  blk_t            link_nxt;
  blk_t            init_val;
  logic            accept;
  logic            alloc_bad;
  logic            free_bad;

  fba_link_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign accept = start && (state_r == S_IDLE);

  // A pop that read the entry just cleared in the same cycle sees old data,
  // so the forwarded value of zero replaces it.
  assign link_nxt = fwd_r ? '0 : rdata;

  // The initial list: block b links to b + 1, the last block and the unused
  // entries (including the null entry) link to zero.
  assign init_val = ((init_cnt_r == '0) || (32'(init_cnt_r) >= NUM_BLOCKS)) ?
                    '0 : BLK_W'(init_cnt_r + 1'b1);

  assign alloc_bad = (32'(in_block_count) > MAX_ALLOC) ||
                     (FREE_W'(in_block_count) > free_r);
  assign free_bad  = (in_block_index == '0) || (32'(in_block_index) > NUM_BLOCKS);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    free_nxt     = free_r;
    remain_nxt   = remain_r;
    init_cnt_nxt = init_cnt_r;
    fwd_nxt      = 1'b0;
    vld_nxt      = 1'b0;
    blk_nxt      = blk_r;
    last_nxt     = last_r;
    stat_nxt     = stat_r;
    mreq.we      = 1'b0;
    mreq.waddr   = head_r;
    mreq.wdata   = '0;
    mreq.raddr   = head_r;

    case (state_r)
      S_INIT: begin
        mreq.we      = 1'b1;
        mreq.waddr   = init_cnt_r;
        mreq.wdata   = init_val;
        init_cnt_nxt = BLK_W'(init_cnt_r + 1'b1);
        if (32'(init_cnt_r) == MEM_D - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_ALLOC) begin
            if (in_block_count == '0) begin
              // Nothing to do and nothing to report.
            end else if (alloc_bad) begin
              vld_nxt  = 1'b1;
              blk_nxt  = '0;
              last_nxt = 1'b1;
              stat_nxt = ST_REFUSED;
            end else begin
              // The read of the head entry is issued in this cycle.
              remain_nxt = CNT_W'(in_block_count);
              free_nxt   = free_r - FREE_W'(in_block_count);
              state_nxt  = S_POP;
            end
          end else begin
            vld_nxt  = 1'b1;
            blk_nxt  = in_block_index;
            last_nxt = 1'b1;
            if (free_bad) begin
              stat_nxt = ST_REFUSED;
            end else begin
              stat_nxt   = ST_OK;
              mreq.we    = 1'b1;
              mreq.waddr = in_block_index;
              mreq.wdata = head_r;
              head_nxt   = in_block_index;
              if (32'(free_r) < NUM_BLOCKS) begin
                free_nxt = free_r + 1'b1;
              end
            end
          end
        end
      end
      S_POP: begin
        vld_nxt    = 1'b1;
        blk_nxt    = head_r;
        last_nxt   = (remain_r == CNT_W'(1));
        stat_nxt   = ST_OK;
        mreq.we    = (head_r != '0);
        mreq.waddr = head_r;
        mreq.wdata = '0;
        mreq.raddr = link_nxt;
        head_nxt   = link_nxt;
        remain_nxt = remain_r - 1'b1;
        fwd_nxt    = (link_nxt == head_r) && (head_r != '0);
        if (remain_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      head_r     <= BLK_W'(1);
      free_r     <= FREE_W'(NUM_BLOCKS);
      remain_r   <= '0;
      init_cnt_r <= '0;
      fwd_r      <= 1'b0;
      vld_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      free_r     <= free_nxt;
      remain_r   <= remain_nxt;
      init_cnt_r <= init_cnt_nxt;
      fwd_r      <= fwd_nxt;
      vld_r      <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    last_r <= last_nxt;
    stat_r <= stat_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = vld_r;
  assign out_block_number = blk_r;
  assign out_last_flag    = last_r;
  assign out_status       = stat_r;

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !vld_r)
    else $error("result during link memory clearing pass");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_r) <= NUM_BLOCKS)
    else $error("free count above block count");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (remain_r != '0))
    else $error("pop with no blocks left to emit");

  a_refused_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && stat_r) |-> last_r)
    else $error("refused result not marked last");

  a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> vld_r)
    else $error("pop cycle gave no result");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the free list block allocator
// Drives allocate and free requests through the start/busy handshake and
// checks every result strobe against a free list predictor or a typed expectation.
// ----------------------------------------------------------------------------
module tb import fba_pkg::*; ();

  // One result of a request: the block handed out or echoed, the end marker
  // and the status.
  typedef struct packed {
    blk_t blk;
    logic last;
    logic status;
  } grant_t;

  // How a row of the directed script gets its expectation: from the
  // predictor, or typed into the row (no result at all, or exactly one).
  localparam int BY_MODEL   = -1;
  localparam int KNOWN_NONE = 0;
  localparam int KNOWN_ONE  = 1;

  typedef struct packed {
    logic             req;
    logic [REQ_W-1:0] cnt;
    blk_t             idx;
    int               known;
    blk_t             blk;
    logic             status;
  } script_row_t;

  localparam int SCRIPT_LEN  = 14;
  localparam int PHASE_ITEMS = 90;
  // The clearing pass after reset is the longest legal quiet stretch, so the
  // watchdog allows several times that.
  localparam int STALL_LIMIT = 3000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_req_type;
  logic [REQ_W-1:0] in_block_count;
  logic [BLK_W-1:0] in_block_index;
  logic             out_valid;
  logic [BLK_W-1:0] out_block_number;
  logic             out_last_flag;
  logic             out_status;

  free_list_block_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_block_count   (in_block_count),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_block_number (out_block_number),
    .out_last_flag    (out_last_flag),
    .out_status       (out_status)
  );

  // Predictor state: the link memory, the head of the free list and the
  // free block count, as the block should hold them after every request
  // taken so far.
  blk_t              next_blk [MEM_D];
  blk_t              list_head;
  logic [FREE_W-1:0] free_cnt;

  // Results owed by the block, oldest first.
  grant_t owed_results [$];
  // Blocks that are valid but not reachable from the head of the list.
  int     lost_blocks [$];

  int errors;
  int quiet_cycles;
  int alloc_reqs;
  int free_reqs;
  int results_seen;
  int refusals;
  int null_pops;

  // Directed script. It starts from the state right after reset (head at
  // block 1, all 511 blocks free), so most single results can be read off
  // directly. Fields that a request does not use carry junk on purpose.
  script_row_t script_rows [0:SCRIPT_LEN-1] = '{
    // First allocation after reset hands out block 1.
    '{REQ_ALLOC, 5'd1,  9'd170, KNOWN_ONE,  9'd1,   ST_OK},
    // Zero-length allocation: nothing comes back.
    '{REQ_ALLOC, 5'd0,  9'd511, KNOWN_NONE, 9'd0,   ST_OK},
    // One above the largest allocation, and the largest count the port takes.
    '{REQ_ALLOC, 5'd17, 9'd0,   KNOWN_ONE,  9'd0,   ST_REFUSED},
    '{REQ_ALLOC, 5'd31, 9'd85,  KNOWN_ONE,  9'd0,   ST_REFUSED},
    // Largest legal allocation: blocks 2 to 17 in a burst.
    '{REQ_ALLOC, 5'd16, 9'd0,   BY_MODEL,   9'd0,   ST_OK},
    // Block 0 is the null link and cannot be freed.
    '{REQ_FREE,  5'd21, 9'd0,   KNOWN_ONE,  9'd0,   ST_REFUSED},
    // The top block goes back on the head; it is still on the list.
    '{REQ_FREE,  5'd31, 9'd511, KNOWN_ONE,  9'd511, ST_OK},
    '{REQ_ALLOC, 5'd2,  9'd0,   BY_MODEL,   9'd0,   ST_OK},
    '{REQ_FREE,  5'd0,  9'd17,  KNOWN_ONE,  9'd17,  ST_OK},
    '{REQ_FREE,  5'd10, 9'd1,   KNOWN_ONE,  9'd1,   ST_OK},
    '{REQ_ALLOC, 5'd1,  9'd0,   BY_MODEL,   9'd0,   ST_OK},
    // Double free of block 5: the second one makes it link to itself, and
    // the three-block allocation then walks off the end of the list and
    // pops the null head.
    '{REQ_FREE,  5'd0,  9'd5,   KNOWN_ONE,  9'd5,   ST_OK},
    '{REQ_FREE,  5'd0,  9'd5,   KNOWN_ONE,  9'd5,   ST_OK},
    '{REQ_ALLOC, 5'd3,  9'd0,   BY_MODEL,   9'd0,   ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_free_list();
    int b;
    next_blk[0] = '0;
    for (b = 1; b < NUM_BLOCKS; b++)
      next_blk[b] = blk_t'(b + 1);
    next_blk[NUM_BLOCKS] = '0;
    list_head = blk_t'(1);
    free_cnt  = FREE_W'(NUM_BLOCKS);
  endfunction

  // Appends one result to the owed queue.
  function automatic void owe_grant(grant_t g);
    owed_results.insert(owed_results.size(), g);
  endfunction

  // Applies one request to the predicted list and queues the results it owes.
  function automatic void model_request(logic req, logic [REQ_W-1:0] cnt, blk_t idx);
    blk_t blk;
    int   n;
    if (req == REQ_ALLOC) begin
      if (cnt == 0)
        return;
      if (cnt > MAX_ALLOC || cnt > free_cnt) begin
        owe_grant(grant_t'{blk_t'(0), 1'b1, ST_REFUSED});
        return;
      end
      // Pop from the head; a popped block has its link cleared. A corrupted
      // list can run dry, and then block 0 keeps coming out.
      for (n = 0; n < cnt; n++) begin
        blk       = list_head;
        list_head = next_blk[blk];
        if (blk != 0)
          next_blk[blk] = '0;
        owe_grant(grant_t'{blk, (n == cnt - 1), ST_OK});
      end
      free_cnt = free_cnt - FREE_W'(cnt);
    end else begin
      if (idx == 0 || idx > NUM_BLOCKS) begin
        owe_grant(grant_t'{idx, 1'b1, ST_REFUSED});
        return;
      end
      // A double free is taken at face value; the count saturates.
      next_blk[idx] = list_head;
      list_head     = idx;
      if (free_cnt < NUM_BLOCKS)
        free_cnt = free_cnt + 1'b1;
      owe_grant(grant_t'{idx, 1'b1, ST_OK});
    end
  endfunction

  // Walks the predicted list from its head and collects every valid block
  // that cannot be reached. The step limit keeps a looped list from hanging.
  function automatic void collect_lost_blocks();
    bit   on_list [MEM_D];
    blk_t b;
    int   steps;
    int   k;
    on_list = '{default: 1'b0};
    b       = list_head;
    steps   = 0;
    while (b != 0 && steps <= NUM_BLOCKS) begin
      on_list[b] = 1'b1;
      b          = next_blk[b];
      steps++;
    end
    lost_blocks.delete();
    for (k = 1; k <= NUM_BLOCKS; k++)
      if (!on_list[k])
        lost_blocks.insert(lost_blocks.size(), k);
  endfunction

  function automatic void note_error(string what);
    errors++;
    if (errors <= 10)
      $display("tb: %s", what);
  endfunction

  // Presents one request and holds it until the block takes it. The request
  // is taken at the first edge where busy is low; start stays high on
  // return, so a back-to-back request needs no second assignment to it.
  task automatic issue_request(input logic req, input logic [REQ_W-1:0] cnt,
                               input blk_t idx, input int known,
                               input blk_t kblk, input logic kstatus);
    int base;
    start          <= 1'b1;
    in_req_type    <= req;
    in_block_count <= cnt;
    in_block_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    // The predictor always runs so that its state follows the block. Rows
    // with a typed expectation replace what it queued.
    base = owed_results.size();
    model_request(req, cnt, idx);
    if (known != BY_MODEL) begin
      while (owed_results.size() > base)
        void'(owed_results.pop_back());
      if (known == KNOWN_ONE)
        owe_grant(grant_t'{kblk, 1'b1, kstatus});
    end
    if (req == REQ_ALLOC)
      alloc_reqs++;
    else
      free_reqs++;
  endtask

  // After a request is taken the sender may go quiet for a while, and such gaps
  // can land anywhere inside a sixteen-block burst.
  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // Holds off new requests until every owed result has come back. It always
  // waits on the clock, so start is never lowered and raised in one step.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  // Builds one random request. Most are well formed: allocations no larger
  // than the free count, and frees of blocks that are off the list. The
  // rest are noise with every field random, which brings in bad indexes,
  // oversize and zero-length allocations and double frees.
  task automatic random_request(output logic req, output logic [REQ_W-1:0] cnt,
                                output blk_t idx);
    int pick;
    int ceiling;
    pick = $urandom_range(99);
    req  = REQ_ALLOC;
    cnt  = REQ_W'($urandom_range(31));
    idx  = BLK_W'($urandom_range(MEM_D - 1));
    if (pick < 7) begin
      req = 1'($urandom_range(1));
      return;
    end
    collect_lost_blocks();
    if ((pick < 62 && free_cnt != 0) || lost_blocks.size() == 0) begin
      req     = REQ_ALLOC;
      ceiling = (free_cnt < MAX_ALLOC) ? int'(free_cnt) : MAX_ALLOC;
      if (ceiling < 1)
        ceiling = 1;
      // Lean toward full bursts so that the list drains in a reasonable time.
      cnt = REQ_W'(($urandom_range(3) == 0) ? ceiling : $urandom_range(1, ceiling));
    end else begin
      req = REQ_FREE;
      idx = BLK_W'(lost_blocks[$urandom_range(lost_blocks.size() - 1)]);
    end
  endtask

  // One random phase with a given sender idle rate. Zero-length allocations
  // do nothing in the block and do not count toward the quota.
  task automatic run_phase(input int gap_pct, input int quota);
    logic             req;
    logic [REQ_W-1:0] cnt;
    blk_t             idx;
    int               taken;
    taken = 0;
    while (taken < quota) begin
      random_request(req, cnt, idx);
      issue_request(req, cnt, idx, BY_MODEL, '0, ST_OK);
      if (req == REQ_FREE || cnt != 0)
        taken++;
      if ($urandom_range(49) == 0)
        wait_drained();
      else
        sender_gap(gap_pct);
    end
  endtask

  // Result checker. The receiver cannot stall, so every strobe is taken at
  // the edge that ends it and is compared with the oldest owed result.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      results_seen++;
      if (out_status === ST_REFUSED)
        refusals++;
      else if (out_block_number === '0)
        null_pops++;
      if (owed_results.size() == 0) begin
        note_error($sformatf("unexpected result: block %0d last %b status %b",
                             out_block_number, out_last_flag, out_status));
      end else begin
        want = owed_results.pop_front();
        if (out_block_number !== want.blk || out_last_flag !== want.last ||
            out_status !== want.status)
          note_error($sformatf({"result mismatch: expected block %0d last %b status %b,",
                                " got block %0d last %b status %b"},
                               want.blk, want.last, want.status,
                               out_block_number, out_last_flag, out_status));
      end
    end
  end

  // Watchdog: any edge that takes a request or a result counts as progress.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: no progress for %0d cycles, %0d results still owed",
                 quiet_cycles, owed_results.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int row;
    errors       = 0;
    quiet_cycles = 0;
    alloc_reqs   = 0;
    free_reqs    = 0;
    results_seen = 0;
    refusals     = 0;
    null_pops    = 0;
    reset_free_list();

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_req_type    <= REQ_ALLOC;
    in_block_count <= '0;
    in_block_index <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its link memory after reset with busy high; the first
    // request simply waits for that to finish.
    for (row = 0; row < SCRIPT_LEN; row++) begin
      issue_request(script_rows[row].req, script_rows[row].cnt, script_rows[row].idx,
                    script_rows[row].known, script_rows[row].blk,
                    script_rows[row].status);
      sender_gap(20);
    end
    wait_drained();

    // The script leaves the list empty with the free count far too high.
    // The random phases put the lost blocks back and drain the count down
    // to where allocations are refused for lack of free blocks.
    run_phase(20, PHASE_ITEMS);
    wait_drained();
    run_phase(62, PHASE_ITEMS);
    wait_drained();
    run_phase(0, PHASE_ITEMS);

    // Let everything in flight come back, then keep watching the outputs to catch
    // any stray strobe.
    wait_drained();
    repeat (8) @(posedge clk);

    $display("tb: %0d requests taken (%0d allocate, %0d free), %0d results checked",
             alloc_reqs + free_reqs, alloc_reqs, free_reqs, results_seen);
    $display("tb: %0d refused results, %0d pops from an empty list, %0d errors",
             refusals, null_pops, errors);
    if (errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
